FILE: rtl/predecessor_path_cost_assert.svh
// assertion macros shared by the predecessor path cost rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef PREDECESSOR_PATH_COST_ASSERT_SVH
`define PREDECESSOR_PATH_COST_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PPC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PPC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ppc_pkg.sv
// shared types, codes and helpers of the predecessor path cost block
// no dependencies; compiled first
package ppc_pkg;

    // field widths
    localparam int POS_W      = 10;
    localparam int ID_W       = 11;
    localparam int WEIGHT_W   = 32;
    localparam int COST_W     = 48;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // default table size
    localparam int MAX_VERTICES_DEF = 1024;

    // item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CYCLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ID      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = CFG_IDX_W'(1);

    // saturation limits
    localparam logic [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
    localparam logic [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

    // one input beat
    typedef struct packed {
        logic                func;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    vertex_id;
        logic [ID_W-1:0]     pred_id;
        logic [WEIGHT_W-1:0] weight;
    } t_item;

    // one result beat
    typedef struct packed {
        logic [COST_W-1:0]   cost;
        logic [STATUS_W-1:0] status;
    } t_result;

    // active configuration seen by the walker
    typedef struct packed {
        logic [ID_W-1:0]    stop_id;
        logic [COUNT_W-1:0] count;
    } t_cfg;

    // table write from a load beat
    typedef struct packed {
        logic                en;
        logic [POS_W-1:0]    pos;
        logic [POS_W-1:0]    vid;
        logic [ID_W-1:0]     pred;
        logic [WEIGHT_W-1:0] weight;
    } t_wr_req;

    // table read requests
    typedef struct packed {
        logic             ent_en;
        logic [POS_W-1:0] ent_addr;
        logic             pov_en;
        logic [POS_W-1:0] pov_addr;
    } t_rd_req;

    // registered read data
    typedef struct packed {
        logic [ID_W-1:0]     pred;
        logic [WEIGHT_W-1:0] weight;
        logic [POS_W-1:0]    pov_pos;
    } t_rd_data;

    // signed add of a weight to a running cost, clamped to the cost range
    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                   input logic [WEIGHT_W-1:0] w);
        logic [COST_W:0] s;
        s = {a[COST_W-1], a} + {{(COST_W-WEIGHT_W+1){w[WEIGHT_W-1]}}, w};
        if (s[COST_W] != s[COST_W-1]) begin
            return s[COST_W] ? COST_MIN : COST_MAX;
        end
        return s[COST_W-1:0];
    endfunction

endpackage

FILE: rtl/ppc_in_if.sv
// input channel of the predecessor path cost block: valid, ready, item fields
// depends on ppc_pkg
interface ppc_in_if;
    import ppc_pkg::*;

    logic                valid;
    logic                ready;
    logic                func;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    vertex_id;
    logic [ID_W-1:0]     pred_id;
    logic [WEIGHT_W-1:0] weight;

    modport source (output valid, func, position, vertex_id, pred_id, weight, input ready);
    modport sink   (input valid, func, position, vertex_id, pred_id, weight, output ready);
endinterface

FILE: rtl/ppc_out_if.sv
// result channel of the predecessor path cost block: valid, ready, cost, status
// depends on ppc_pkg
interface ppc_out_if;
    import ppc_pkg::*;

    logic                valid;
    logic                ready;
    logic [COST_W-1:0]   cost;
    logic [STATUS_W-1:0] status;

    modport source (output valid, cost, status, input ready);
    modport sink   (input valid, cost, status, output ready);
endinterface

FILE: rtl/ppc_store.sv
// table memories: entry store (pred, weight) by position and position store by vertex
// depends on ppc_pkg; driven by ppc_walker
module ppc_store #(
    parameter int MAX_VERTICES = ppc_pkg::MAX_VERTICES_DEF
) (
    input  logic               i_clk,
    input  ppc_pkg::t_wr_req   i_wr,
    input  ppc_pkg::t_rd_req   i_rd,
    output ppc_pkg::t_rd_data  o_rd
);
    import ppc_pkg::*;

    // positions never exceed the position field, so deeper storage is unreachable
    localparam int DEPTH = (MAX_VERTICES < (1 << POS_W)) ? MAX_VERTICES : (1 << POS_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int ENT_W = ID_W + WEIGHT_W;

    logic [ENT_W-1:0] r_ent_mem [DEPTH];
    logic [POS_W-1:0] r_pov_mem [DEPTH];
    logic [ENT_W-1:0] r_ent_q;
    logic [POS_W-1:0] r_pov_q;

    // entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_ent_mem[i_wr.pos[AW-1:0]] <= {i_wr.pred, i_wr.weight};
        end
        if (i_rd.ent_en) begin
            r_ent_q <= r_ent_mem[i_rd.ent_addr[AW-1:0]];
        end
    end

    // vertex to position memory
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_pov_mem[i_wr.vid[AW-1:0]] <= i_wr.pos;
        end
        if (i_rd.pov_en) begin
            r_pov_q <= r_pov_mem[i_rd.pov_addr[AW-1:0]];
        end
    end

    assign o_rd.pred    = r_ent_q[ENT_W-1:WEIGHT_W];
    assign o_rd.weight  = r_ent_q[WEIGHT_W-1:0];
    assign o_rd.pov_pos = r_pov_q;
endmodule

FILE: rtl/ppc_walker.sv
// sequencer: applies loads and chases predecessors through the table for queries
// depends on ppc_pkg; drives ppc_store
module ppc_walker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ppc_pkg::t_item     i_item,
    input  ppc_pkg::t_cfg      i_cfg,
    output ppc_pkg::t_wr_req   o_wr,
    output ppc_pkg::t_rd_req   o_rd,
    input  ppc_pkg::t_rd_data  i_rd,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output ppc_pkg::t_result   o_res
);
    import ppc_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ENT    = 2'd1;
    localparam logic [1:0] S_POV    = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [COST_W-1:0]   r_sum, n_sum;
    logic [COUNT_W-1:0]  r_entries, n_entries;
    logic [STATUS_W-1:0] r_status, n_status;

    logic              accept;
    logic              pos_ok, vid_ok;
    logic              pred_stop, pred_bad, p_bad, walk_long;
    logic [COST_W-1:0] ent_sum;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // range checks against the active count
    assign pos_ok    = {1'b0, i_item.position} < i_cfg.count;
    assign vid_ok    = {1'b0, i_item.vertex_id} < i_cfg.count;
    assign pred_stop = (i_rd.pred == i_cfg.stop_id);
    assign pred_bad  = i_rd.pred[ID_W-1] || ({1'b0, i_rd.pred[POS_W-1:0]} >= i_cfg.count);
    assign p_bad     = {1'b0, i_rd.pov_pos} >= i_cfg.count;
    assign walk_long = (r_entries >= i_cfg.count);
    assign ent_sum   = sat_add(r_sum, i_rd.weight);

    // load beats write straight into the table
    assign o_wr.en     = accept && (i_item.func == FUNC_LOAD) && pos_ok && vid_ok;
    assign o_wr.pos    = i_item.position;
    assign o_wr.vid    = i_item.vertex_id;
    assign o_wr.pred   = i_item.pred_id;
    assign o_wr.weight = i_item.weight;

    // walk sequencer
    always_comb begin
        n_state   = r_state;
        n_sum     = r_sum;
        n_entries = r_entries;
        n_status  = r_status;
        o_rd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_item.func == FUNC_QUERY)) begin
                    if (!pos_ok) begin
                        n_status = ST_RANGE;
                        n_state  = S_RESULT;
                    end else begin
                        o_rd.ent_en   = 1'b1;
                        o_rd.ent_addr = i_item.position;
                        n_sum         = '0;
                        n_entries     = COUNT_W'(1);
                        n_status      = ST_OK;
                        n_state       = S_ENT;
                    end
                end
            end
            S_ENT: begin
                n_sum = ent_sum;
                if (pred_stop) begin
                    n_state = S_RESULT;
                end else if (pred_bad) begin
                    n_status = ST_RANGE;
                    n_state  = S_RESULT;
                end else begin
                    o_rd.pov_en   = 1'b1;
                    o_rd.pov_addr = i_rd.pred[POS_W-1:0];
                    n_state       = S_POV;
                end
            end
            S_POV: begin
                if (p_bad) begin
                    n_status = ST_RANGE;
                    n_state  = S_RESULT;
                end else if (walk_long) begin
                    n_status = ST_CYCLE;
                    n_state  = S_RESULT;
                end else begin
                    n_entries     = r_entries + COUNT_W'(1);
                    o_rd.ent_en   = 1'b1;
                    o_rd.ent_addr = i_rd.pov_pos;
                    n_state       = S_ENT;
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // walk data
    always_ff @(posedge i_clk) begin
        r_sum     <= n_sum;
        r_entries <= n_entries;
        r_status  <= n_status;
    end

    assign o_res_valid = (r_state == S_RESULT);
    assign o_res.cost   = (r_status == ST_OK) ? r_sum : '0;
    assign o_res.status = r_status;
endmodule

FILE: rtl/predecessor_path_cost.sv
// top level of the predecessor path cost block: config registers, result register
// depends on ppc_pkg, ppc_in_if, ppc_out_if, ppc_store, ppc_walker and the assert header
//
// usage: the input channel carries load beats (func 0) that write one table
// position and query beats (func 1) that name a position; each query gives one
// result beat of saturated path cost and status, loads give none.
// a load leaves the sequencer idle, so the block stays ready for the next beat.
// a query holds the input until the output register takes its result: each hop
// is one read of the vertex-to-position memory and one read of the entry memory,
// both registered, and the hops are strictly dependent. the result waits in the
// walker's result state until the output register is free. the user must write
// stop_id and vertex_count through the plain write port only while idle; the
// block itself does not enforce it. reset clears the sequencer and the output
// valid and restores stop_id -1 and vertex_count 1024; the table memories keep
// no reset and need no clearing pass. when the receiver stalls, the finished
// result waits in the output register while the next beat is taken; a further
// query ends its walk and then holds until the output register frees up.
`include "predecessor_path_cost_assert.svh"

module predecessor_path_cost #(
    parameter int MAX_VERTICES = ppc_pkg::MAX_VERTICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ppc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ppc_in_if.sink                            i_in,
    ppc_out_if.source                         o_out
);
    import ppc_pkg::*;

    // largest count the count field can express, limited by the table size
    localparam int               CAP   = (MAX_VERTICES < 2047) ? MAX_VERTICES : 2047;
    localparam logic [COUNT_W-1:0] CAP_N = COUNT_W'(CAP);

    logic [ID_W-1:0]    r_stop_id;
    logic [COUNT_W-1:0] r_vertex_count;
    logic               r_out_valid;
    t_result            r_out;

    t_item    item;
    t_cfg     cfg;
    t_wr_req  wr;
    t_rd_req  rd;
    t_rd_data rd_data;
    t_result  res;
    logic     res_valid;
    logic     res_ready;
    logic     in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_id      <= {ID_W{1'b1}};
            r_vertex_count <= COUNT_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STOP_ID:      r_stop_id      <= i_cfg_data[ID_W-1:0];
                REG_VERTEX_COUNT: r_vertex_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // active count limited to the table size
    assign cfg.stop_id = r_stop_id;
    assign cfg.count   = (r_vertex_count > CAP_N) ? CAP_N : r_vertex_count;

    // input beat fields
    assign item.func      = i_in.func;
    assign item.position  = i_in.position;
    assign item.vertex_id = i_in.vertex_id;
    assign item.pred_id   = i_in.pred_id;
    assign item.weight    = i_in.weight;
    assign i_in.ready     = in_ready;

    ppc_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_item      (item),
        .i_cfg       (cfg),
        .o_wr        (wr),
        .o_rd        (rd),
        .i_rd        (rd_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    ppc_store #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_store (
        .i_clk (i_clk),
        .i_wr  (wr),
        .i_rd  (rd),
        .o_rd  (rd_data)
    );

    // output register between the walker and the receiver
    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.cost   = r_out.cost;
    assign o_out.status = r_out.status;

    // a load beat never stalls the next beat
    `PPC_ASSERT_NXT(a_load_one_cycle, i_clk, i_rst_n, i_in.valid && in_ready && (i_in.func == FUNC_LOAD), in_ready, "load beat left the block busy")
    // a query beat always occupies the sequencer
    `PPC_ASSERT_NXT(a_query_busy, i_clk, i_rst_n, i_in.valid && in_ready && (i_in.func == FUNC_QUERY), !in_ready, "query beat did not start a walk")
    // failed walks report zero cost
    `PPC_ASSERT_IMP(a_err_zero_cost, i_clk, i_rst_n, r_out_valid && (r_out.status != ST_OK), r_out.cost == '0, "nonzero cost with error status")
endmodule

FILE: bench/tb_top.sv
// testbench of predecessor_path_cost: a directed table, then random tree phases
// checked beat by beat against a path-cost predictor of its own
// depends on ppc_pkg, ppc_in_if, ppc_out_if and the predecessor_path_cost rtl
module tb_top;
    import ppc_pkg::*;

    localparam int TABLE_DEPTH    = MAX_VERTICES_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam longint COST_HI    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint COST_LO    = -COST_HI - 1;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    // one row of the directed table: a register write or an input beat
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_item                 beat;
        bit                    typed;
        t_result               res;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ppc_in_if  in_ch ();
    ppc_out_if out_ch ();

    predecessor_path_cost dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the table and the registers
    logic [ID_W-1:0]     pred_mem      [TABLE_DEPTH];
    logic [WEIGHT_W-1:0] weight_mem    [TABLE_DEPTH];
    logic [POS_W-1:0]    pos_of_vertex [TABLE_DEPTH];
    bit                  entry_written [TABLE_DEPTH];
    bit                  vertex_written[TABLE_DEPTH];
    logic [ID_W-1:0]     stop_mirror  = '1;
    logic [COUNT_W-1:0]  count_mirror = COUNT_W'(1024);

    t_result expected_costs[$];
    int      mismatches     = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      holds_asked    = 0;

    function automatic int active_n();
        return (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_mirror);
    endfunction

    // walk the predecessor chain; safe drops to 0 when the walk would touch an unwritten entry
    function automatic void walk_cost(input logic [POS_W-1:0] pos, output t_result res,
                                      output bit safe);
        int                  n;
        int                  stop;
        int                  pred;
        int                  p;
        int                  hops;
        longint              sum;
        logic [STATUS_W-1:0] st;
        n    = active_n();
        stop = int'($signed(stop_mirror));
        hops = 1;
        sum  = 0;
        st   = ST_OK;
        safe = 1'b1;
        if (int'(pos) >= n) begin
            st = ST_RANGE;
        end else begin
            safe = entry_written[pos];
            sum  = longint'($signed(weight_mem[pos]));
            pred = int'($signed(pred_mem[pos]));
            while (safe && pred != stop) begin
                if (pred < 0 || pred >= n) begin
                    st = ST_RANGE;
                    break;
                end
                if (!vertex_written[pred]) begin
                    safe = 1'b0;
                    break;
                end
                p = int'(pos_of_vertex[pred]);
                if (p >= n) begin
                    st = ST_RANGE;
                    break;
                end
                if (hops >= n) begin
                    st = ST_CYCLE;
                    break;
                end
                hops++;
                sum += longint'($signed(weight_mem[p]));
                if (sum > COST_HI) sum = COST_HI;
                else if (sum < COST_LO) sum = COST_LO;
                pred = int'($signed(pred_mem[p]));
            end
        end
        res.status = st;
        res.cost   = (st == ST_OK) ? sum[COST_W-1:0] : '0;
    endfunction

    // a load beat lands only when both position and vertex are inside the count
    function automatic void apply_load(input t_item b);
        int n;
        n = active_n();
        if (int'(b.position) < n && int'(b.vertex_id) < n) begin
            pred_mem[b.position]       = b.pred_id;
            weight_mem[b.position]     = b.weight;
            pos_of_vertex[b.vertex_id] = b.position;
            entry_written[b.position]  = 1'b1;
            vertex_written[b.vertex_id] = 1'b1;
        end
    endfunction

    function automatic t_item make_beat(input logic f, input int pos, input int vid,
                                        input logic [ID_W-1:0] pred,
                                        input logic [WEIGHT_W-1:0] w);
        t_item b;
        b.func      = f;
        b.position  = POS_W'(pos);
        b.vertex_id = POS_W'(vid);
        b.pred_id   = pred;
        b.weight    = w;
        return b;
    endfunction

    function automatic t_dir_row load_row(input int pos, input int vid,
                                          input logic [ID_W-1:0] pred,
                                          input logic [WEIGHT_W-1:0] w);
        t_dir_row r;
        r.is_cfg  = 1'b0;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.beat    = make_beat(FUNC_LOAD, pos, vid, pred, w);
        r.typed   = 1'b0;
        r.res     = '0;
        return r;
    endfunction

    function automatic t_dir_row query_row(input int pos, input bit typed,
                                           input logic [COST_W-1:0] cost,
                                           input logic [STATUS_W-1:0] st);
        t_dir_row r;
        r.is_cfg     = 1'b0;
        r.reg_idx    = '0;
        r.reg_val    = '0;
        r.beat       = make_beat(FUNC_QUERY, pos, 0, '0, '0);
        r.typed      = typed;
        r.res.cost   = cost;
        r.res.status = st;
        return r;
    endfunction

    function automatic t_dir_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        t_dir_row r;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.beat    = '0;
        r.typed   = 1'b0;
        r.res     = '0;
        return r;
    endfunction

    // weights lean toward the extremes
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(7, 0))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return WEIGHT_W'(int'($urandom_range(512, 0)) - 256);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // offer one beat, wait for the handshake, then record what it should produce
    task automatic drive_beat(input t_item b, input bit typed, input t_result typed_res);
        t_result res;
        bit      safe;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= b.func;
        in_ch.position  <= b.position;
        in_ch.vertex_id <= b.vertex_id;
        in_ch.pred_id   <= b.pred_id;
        in_ch.weight    <= b.weight;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (b.func == FUNC_LOAD) begin
            apply_load(b);
        end else begin
            walk_cost(b.position, res, safe);
            expected_costs.push_back(typed ? typed_res : res);
        end
    endtask

    // register write once the block has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        in_ch.valid <= 1'b0;
        while (expected_costs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_STOP_ID) stop_mirror = val;
        else if (idx == REG_VERTEX_COUNT) count_mirror = val;
    endtask

    // one setting: load a predecessor tree, then mostly queries with rewiring and noise
    task automatic run_phase(input logic [ID_W-1:0] stop, input logic [COUNT_W-1:0] count,
                             input int tree_size, input int beats, input t_idle mode,
                             input bit chain, input bit hold);
        int              n;
        int              m;
        int              k;
        int              tries;
        int              pick;
        int              tmp;
        int              pos_pool[$];
        int              vid_pool[$];
        logic [ID_W-1:0] pred;
        t_item           b;
        t_result         res;
        bit              safe;
        case (mode)
            IDLE_SEND: begin
                send_idle_pct  <= 63;
                recv_stall_pct <= 0;
            end
            IDLE_RECV: begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 63;
            end
            IDLE_BOTH: begin
                send_idle_pct  <= 36;
                recv_stall_pct <= 36;
            end
            default: begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 0;
            end
        endcase
        write_reg(REG_STOP_ID, stop);
        write_reg(REG_VERTEX_COUNT, count);
        n = active_n();
        m = (tree_size < n) ? tree_size : n;

        // distinct positions and vertex ids inside the count
        for (k = 0; k < n; k++) begin
            pos_pool.push_back(k);
            vid_pool.push_back(k);
        end
        for (k = n - 1; k > 0; k--) begin
            pick = $urandom_range(k, 0);
            tmp = pos_pool[k];
            pos_pool[k] = pos_pool[pick];
            pos_pool[pick] = tmp;
            pick = $urandom_range(k, 0);
            tmp = vid_pool[k];
            vid_pool[k] = vid_pool[pick];
            vid_pool[pick] = tmp;
        end

        // tree loads: the first vertex is the root, the rest hang off earlier vertices
        for (k = 0; k < m; k++) begin
            if (k == 0) pred = stop;
            else pred = ID_W'(vid_pool[chain ? k - 1 : $urandom_range(k - 1, 0)]);
            drive_beat(make_beat(FUNC_LOAD, pos_pool[k], vid_pool[k], pred, pick_weight()),
                       1'b0, '0);
        end

        if (hold) holds_asked <= holds_asked + 1;

        for (k = 0; k < beats; k++) begin
            tries = 0;
            safe  = 1'b0;
            if ($urandom_range(99, 0) < 65) begin
                while (!safe && tries < 8) begin
                    if (m > 0 && $urandom_range(4, 0) != 0) pick = pos_pool[$urandom_range(m - 1, 0)];
                    else pick = $urandom_range(TABLE_DEPTH - 1, 0);
                    walk_cost(POS_W'(pick), res, safe);
                    tries++;
                end
            end
            if (safe) begin
                b = make_beat(FUNC_QUERY, pick, $urandom, ID_W'($urandom), $urandom);
            end else if (m > 0 && $urandom_range(99, 0) < 70) begin
                // rewire a tree entry to another tree vertex or to the root marker
                pick = $urandom_range(m - 1, 0);
                tmp  = $urandom_range(m, 0);
                pred = (tmp == m) ? stop : ID_W'(vid_pool[tmp]);
                b = make_beat(FUNC_LOAD, pos_pool[pick], vid_pool[pick], pred, pick_weight());
            end else begin
                b = make_beat(FUNC_LOAD, $urandom, $urandom, ID_W'($urandom), pick_weight());
            end
            drive_beat(b, 1'b0, '0);
        end
    endtask

    // result beats against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_costs.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat: cost %h status %0d",
                                          out_ch.cost, out_ch.status));
            end else begin
                want = expected_costs.pop_front();
                if (out_ch.cost !== want.cost)
                    report_mismatch($sformatf("cost %h, predicted %h", out_ch.cost, want.cost));
                if (out_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              out_ch.status, want.status));
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when asked
    initial begin : result_sink
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles with no beat moving
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin : stimulus
        t_dir_row dir_tab[$];
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.func      <= FUNC_LOAD;
        in_ch.position  <= '0;
        in_ch.vertex_id <= '0;
        in_ch.pred_id   <= '0;
        in_ch.weight    <= '0;

        // reset registers first: stop marker -1, full count
        dir_tab = '{
            load_row(0, 0, 11'h7FF, 32'h7FFF_FFFF),
            query_row(0, 1'b1, 48'h0000_7FFF_FFFF, ST_OK),
            load_row(1023, 1023, 11'd0, 32'h7FFF_FFFF),
            query_row(1023, 1'b1, 48'h0000_FFFF_FFFE, ST_OK),
            load_row(1, 1, 11'h7FF, 32'h8000_0000),
            query_row(1, 1'b1, 48'hFFFF_8000_0000, ST_OK),
            // most negative predecessor that is not the stop marker
            load_row(2, 2, 11'h400, 32'd5),
            query_row(2, 1'b1, '0, ST_RANGE),
            // self loop runs into the walk limit
            load_row(3, 3, 11'd3, 32'd1),
            query_row(3, 1'b1, '0, ST_CYCLE),
            load_row(700, 4, 11'h7FF, 32'h0001_0000),
            load_row(5, 5, 11'd4, 32'h0001_8000),
            query_row(5, 1'b0, '0, ST_OK),
            // shrink the count: vertex 4 now maps past it
            reg_row(REG_VERTEX_COUNT, 11'd6),
            query_row(5, 1'b1, '0, ST_RANGE),
            query_row(6, 1'b1, '0, ST_RANGE),
            // loads with position or vertex past the count are dropped
            load_row(9, 1, 11'h7FF, 32'd1),
            load_row(1, 9, 11'h7FF, 32'd1),
            query_row(1, 1'b1, 48'hFFFF_8000_0000, ST_OK),
            // zero count
            reg_row(REG_VERTEX_COUNT, 11'd0),
            load_row(0, 0, 11'h7FF, 32'd0),
            query_row(0, 1'b1, '0, ST_RANGE),
            // stop marker 0, count above the table size
            reg_row(REG_STOP_ID, 11'd0),
            reg_row(REG_VERTEX_COUNT, 11'h7FF),
            query_row(1023, 1'b1, 48'h0000_7FFF_FFFF, ST_OK),
            query_row(0, 1'b1, '0, ST_RANGE)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[r]) begin
            if (dir_tab[r].is_cfg) write_reg(dir_tab[r].reg_idx, dir_tab[r].reg_val);
            else drive_beat(dir_tab[r].beat, dir_tab[r].typed, dir_tab[r].res);
        end

        run_phase(11'h7FF, 11'd16, 16, 100, IDLE_NONE, 1'b0, 1'b0);
        run_phase(11'd1023, 11'd1024, 48, 100, IDLE_SEND, 1'b0, 1'b0);
        run_phase(11'd0, 11'd2, 2, 80, IDLE_RECV, 1'b0, 1'b1);
        run_phase(ID_W'($urandom), 11'h7FF, 48, 100, IDLE_BOTH, 1'b0, 1'b0);
        run_phase(11'h7FF, 11'd64, 64, 100, IDLE_NONE, 1'b1, 1'b1);
        run_phase(ID_W'($urandom_range(32, 0)), 11'd33, 33, 100, IDLE_SEND, 1'b0, 1'b0);
        run_phase(11'h7FF, 11'd0, 0, 20, IDLE_RECV, 1'b0, 1'b0);
        run_phase(11'd1023, 11'd1, 1, 60, IDLE_BOTH, 1'b0, 1'b0);

        // drain
        in_ch.valid <= 1'b0;
        while (expected_costs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
